// ----- rtl/core/isl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iSLIP scheduler package
// Shared widths and the arbiter result type of the crossbar scheduler.
// ----------------------------------------------------------------------------
package isl_pkg;

    // Largest crossbar supported by the fixed-width fields.
    localparam int MAX_PORTS = 8;
    // Width of one port index in the match map.
    localparam int MAP_W     = 3;
    // Width of the request matrix field.
    localparam int REQ_W     = 64;
    // Width of the matched-inputs field.
    localparam int MATCH_W   = MAX_PORTS;
    // Width of the match map field.
    localparam int MAPF_W    = MAX_PORTS * MAP_W;
    // Width of the result tdata (fields packed, byte aligned).
    localparam int OUT_W     = 32;

    // Outcome of one round-robin arbiter.
    typedef struct packed {
        logic             valid;
        logic [MAP_W-1:0] idx;
    } arb_result_t;

endpackage : isl_pkg
`default_nettype wire

// ----- rtl/core/islip_crossbar_scheduler.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iSLIP crossbar scheduler
// Single-iteration iSLIP matcher for a PORTS x PORTS crossbar.
// ----------------------------------------------------------------------------
// Each item on the slave stream is one cell slot: a request matrix with bit
// input*PORTS+output set when that virtual output queue holds a cell. Bits
// at PORTS*PORTS and above are ignored. Every output grants the requesting
// input that comes first from its grant pointer, and every input accepts the
// granting output that comes first from its accept pointer. On an accepted
// grant the input's accept pointer moves one past the output and the
// output's grant pointer one past the input; nothing else moves them. Each
// item yields exactly one result item: matched_inputs (bit i set when input
// i was matched) and match_map (three bits per input holding its output,
// zero when unmatched; ports at or above PORTS read as zero). The block
// takes one item every clock cycle while the result stream is not stalled.
// The request is captured in an input register at the edge that accepts
// the item, and the grant arbiters and the accept arbiters settle between
// that register and the result register, which loads when the input stage
// advances. The pointers update on the same edge that loads the result, so
// the next slot already sees them. A stalled result holds the pipeline; the
// input side keeps accepting while the input stage can move.
// ----------------------------------------------------------------------------
module islip_crossbar_scheduler #(
    parameter int PORTS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Slave stream, tdata bits: [63:0] request_matrix.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,
    // Master stream, tdata bits: [7:0] matched_inputs, [31:8] match_map.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata
);
    import isl_pkg::*;

    localparam int PW = $clog2(PORTS);

    // Pipeline control.
    logic               in_vld_reg;
    logic               out_vld_reg;
    logic               advance;

    // Captured request matrix and registered result.
    logic [REQ_W-1:0]   req_reg;
    logic [OUT_W-1:0]   result_reg;
    logic [OUT_W-1:0]   result_next;

    // Pointers: one grant pointer per output, one accept pointer per input.
    logic [PORTS-1:0][PW-1:0] grant_ptr_reg;
    logic [PORTS-1:0][PW-1:0] grant_ptr_next;
    logic [PORTS-1:0][PW-1:0] accept_ptr_reg;
    logic [PORTS-1:0][PW-1:0] accept_ptr_next;

    // Arbiter request vectors and outcomes.
    logic [PORTS-1:0][PORTS-1:0] grant_req;
    logic [PORTS-1:0][PORTS-1:0] accept_req;
    arb_result_t                 grant_res  [PORTS];
    arb_result_t                 accept_res [PORTS];

    // Outputs taken by the current matching, one bit per output.
    logic [PORTS-1:0]            out_taken;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(PORTS - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // The input stage moves on whenever the result stage is free or drains.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = result_reg;

    // Grant phase: output o looks at column o of the request matrix.
    always_comb begin
        grant_req = '0;
        for (int o = 0; o < PORTS; o++) begin
            for (int i = 0; i < PORTS; i++) begin
                grant_req[o][i] = req_reg[i * PORTS + o];
            end
        end
    end

    // Accept phase: input i sees the outputs that granted it.
    always_comb begin
        accept_req = '0;
        for (int i = 0; i < PORTS; i++) begin
            for (int o = 0; o < PORTS; o++) begin
                accept_req[i][o] = grant_res[o].valid && (grant_res[o].idx == MAP_W'(i));
            end
        end
    end

    for (genvar g = 0; g < PORTS; g++) begin : g_arb
        isl_rr_arbiter #(
            .N (PORTS)
        ) u_grant_arb (
            .req    (grant_req[g]),
            .ptr    (grant_ptr_reg[g]),
            .result (grant_res[g])
        );

        isl_rr_arbiter #(
            .N (PORTS)
        ) u_accept_arb (
            .req    (accept_req[g]),
            .ptr    (accept_ptr_reg[g]),
            .result (accept_res[g])
        );
    end

    // Result packing and pointer updates. An output is accepted by at most
    // one input, since it granted only one, so the updates never collide.
    always_comb begin
        result_next     = '0;
        out_taken       = '0;
        grant_ptr_next  = grant_ptr_reg;
        accept_ptr_next = accept_ptr_reg;
        for (int i = 0; i < PORTS; i++) begin
            if (accept_res[i].valid) begin
                result_next[i]                            = 1'b1;
                result_next[MATCH_W + MAP_W * i +: MAP_W] = accept_res[i].idx;
                out_taken[accept_res[i].idx[PW-1:0]]      = 1'b1;
                if (advance) begin
                    accept_ptr_next[i] = ptr_inc(accept_res[i].idx[PW-1:0]);
                end
            end
        end
        for (int o = 0; o < PORTS; o++) begin
            for (int i = 0; i < PORTS; i++) begin
                if (advance && accept_res[i].valid && (accept_res[i].idx == MAP_W'(o))) begin
                    grant_ptr_next[o] = ptr_inc(PW'(i));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            grant_ptr_reg  <= '0;
            accept_ptr_reg <= '0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
            grant_ptr_reg  <= grant_ptr_next;
            accept_ptr_reg <= accept_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg <= s_tdata;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    // With both stages full and the result stalled, no new item may enter.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_vld_reg && !m_tready) |-> !s_tready)
        else $error("input accepted while pipeline is full and stalled");

    // Pointers move only when a slot is actually scheduled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(grant_ptr_reg) && $stable(accept_ptr_reg)))
        else $error("pointers moved without a scheduled slot");

    // A result without matches carries an all-zero map.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[7:0] == 8'd0)) |-> (m_tdata[31:8] == 24'd0))
        else $error("match map set for an empty matching");

    // Every matched input maps to a distinct output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |-> ($countones(out_taken) == $countones(result_next[MATCH_W-1:0])))
        else $error("two inputs matched to the same output");

endmodule : islip_crossbar_scheduler
`default_nettype wire

// ----- rtl/core/isl_rr_arbiter.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Round-robin arbiter
// Picks the first set request at or after the pointer, wrapping modulo N.
// ----------------------------------------------------------------------------
module isl_rr_arbiter #(
    parameter int N = 8
) (
    input  wire logic [N-1:0]                 req,
    input  wire logic [$clog2(N)-1:0]         ptr,
    output isl_pkg::arb_result_t              result
);
    import isl_pkg::*;

    localparam int IW = $clog2(N);

    // At most N narrow steps; the first hit wins.
    always_comb begin
        logic [IW:0] cand;
        logic        found;
        found  = 1'b0;
        cand   = '0;
        result = '0;
        for (int d = 0; d < N; d++) begin
            cand = {1'b0, ptr} + (IW+1)'(d);
            if (cand >= (IW+1)'(N)) begin
                cand = cand - (IW+1)'(N);
            end
            if (!found && req[cand[IW-1:0]]) begin
                found        = 1'b1;
                result.valid = 1'b1;
                result.idx   = MAP_W'(cand[IW-1:0]);
            end
        end
    end

endmodule : isl_rr_arbiter
`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iSLIP crossbar scheduler testbench
// Drives request matrices into the scheduler with random gaps and stalls on
// both streams. A predictor keeps its own grant and accept pointers and
// checks every matching that the block returns.
// ----------------------------------------------------------------------------
module tb;
    import isl_pkg::*;

    // Crossbar size under test. The predictor follows this value as well.
    localparam int PORTS       = 8;
    // Generous cycle budget.
    localparam int CYCLE_LIMIT = 200000;
    // Number of random items after the directed part.
    localparam int RANDOM_ITEMS = 1250;
    // Input register plus result register.
    localparam int DRAIN_CYCLES = 8;
    // Chance in percent that a side idles in a given cycle.
    localparam int IDLE_PCT     = 15;

    // One expected result item, in tdata field order.
    typedef struct packed {
        logic [MAPF_W-1:0]  match_map;
        logic [MATCH_W-1:0] matched_inputs;
    } slot_match_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [REQ_W-1:0]   s_tdata = '0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;

    // Request matrices waiting to be offered, and matchings waiting to arrive.
    logic [REQ_W-1:0]   pending_requests[$];
    slot_match_t        expected_matches[$];

    // The predictor's copy of the scheduler state.
    logic [MAP_W-1:0]   grant_ptr[MAX_PORTS];
    logic [MAP_W-1:0]   accept_ptr[MAX_PORTS];

    int unsigned        cycle_count = 0;
    int unsigned        slots_sent = 0;
    int unsigned        results_checked = 0;
    int unsigned        full_matchings = 0;
    int unsigned        empty_slots = 0;
    int unsigned        error_count = 0;
    // High during a stretch of cycles in which neither side idles.
    logic               steady_flow = 1'b0;

    islip_crossbar_scheduler #(
        .PORTS(PORTS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Appends one request matrix to the stimulus queue.
    task automatic queue_request(input logic [REQ_W-1:0] r);
        pending_requests.insert(pending_requests.size(), r);
    endtask

    // Bit mask of the ports that exist in this configuration.
    function automatic logic [MATCH_W-1:0] port_mask();
        return MATCH_W'((1 << PORTS) - 1);
    endfunction

    // Request matrix in which input i asks for output (i + shift) mod PORTS,
    // a full permutation that can be matched completely.
    function automatic logic [REQ_W-1:0] shifted_permutation(int shift);
        logic [REQ_W-1:0] req;
        req = '0;
        for (int i = 0; i < PORTS; i++) begin
            req[i * PORTS + (i + shift) % PORTS] = 1'b1;
        end
        return req;
    endfunction

    // Every input asks for one output: a hotspot that only the grant
    // pointer of that output resolves.
    function automatic logic [REQ_W-1:0] column_requests(int o);
        logic [REQ_W-1:0] req;
        req = '0;
        for (int i = 0; i < PORTS; i++) begin
            req[i * PORTS + o] = 1'b1;
        end
        return req;
    endfunction

    // One input asks for every output; only its accept pointer decides.
    function automatic logic [REQ_W-1:0] row_requests(int i);
        logic [REQ_W-1:0] req;
        req = '0;
        for (int o = 0; o < PORTS; o++) begin
            req[i * PORTS + o] = 1'b1;
        end
        return req;
    endfunction

    // One cell slot of single-iteration iSLIP. Works out the matching for
    // the request matrix and moves the pointers of every accepted grant.
    function automatic slot_match_t islip_slot_match(logic [REQ_W-1:0] req);
        int          granted_to[MAX_PORTS];
        int          cand;
        slot_match_t res;
        res = '0;
        // Grant phase: each output picks the first requester from its pointer.
        for (int o = 0; o < MAX_PORTS; o++) begin
            granted_to[o] = -1;
            if (o < PORTS) begin
                for (int d = 0; d < PORTS; d++) begin
                    cand = (int'(grant_ptr[o]) + d) % PORTS;
                    if (req[cand * PORTS + o]) begin
                        granted_to[o] = cand;
                        break;
                    end
                end
            end
        end
        // Accept phase: each input takes the first granting output from its
        // pointer. Grants were fixed above, so updating pointers here is safe.
        for (int i = 0; i < PORTS; i++) begin
            for (int d = 0; d < PORTS; d++) begin
                cand = (int'(accept_ptr[i]) + d) % PORTS;
                if (granted_to[cand] == i) begin
                    res.matched_inputs[i] = 1'b1;
                    res.match_map[MAP_W * i +: MAP_W] = MAP_W'(cand);
                    accept_ptr[i] = MAP_W'((cand + 1) % PORTS);
                    grant_ptr[cand] = MAP_W'((i + 1) % PORTS);
                    break;
                end
            end
        end
        return res;
    endfunction

    // Cycle counter, the stretch without idling, and the timeout.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        steady_flow <= (cycle_count >= 600) && (cycle_count < 1000);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_matches.size());
            $display("tb: errors");
            $finish;
        end
    end

    // Driver. An item is predicted at the edge that accepts it, before it has
    // passed the input and result registers, so the expectation is always
    // queued in time. The valid only changes when no item is held, or when
    // the held one is taken at this edge.
    always @(posedge aclk) begin
        slot_match_t res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            for (int k = 0; k < MAX_PORTS; k++) begin
                grant_ptr[k]  = '0;
                accept_ptr[k] = '0;
            end
        end else begin
            if (s_tvalid && s_tready) begin
                res = islip_slot_match(s_tdata);
                expected_matches.insert(expected_matches.size(), res);
                slots_sent++;
                if (res.matched_inputs == port_mask())
                    full_matchings++;
                if (res.matched_inputs == '0)
                    empty_slots++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() > 0 &&
                    (steady_flow || $urandom_range(99) >= IDLE_PCT)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_requests.pop_front();
                end else begin
                    // Idle: the data bus carries junk the block must ignore.
                    s_tvalid <= 1'b0;
                    s_tdata  <= {$urandom, $urandom};
                end
            end
        end
    end

    // Monitor. Stalls the result stream at random and checks each accepted
    // result against the oldest expectation, field by field.
    always @(posedge aclk) begin
        slot_match_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
            if (m_tvalid && m_tready) begin
                if (expected_matches.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("tb: result %h arrived with nothing expected",
                                 m_tdata);
                end else begin
                    want = expected_matches.pop_front();
                    results_checked++;
                    if (m_tdata[MATCH_W-1:0] !== want.matched_inputs ||
                        m_tdata[MATCH_W +: MAPF_W] !== want.match_map) begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"tb: result %0d mismatch: matched_inputs ",
                                      "exp %h got %h, match_map exp %h got %h"},
                                     results_checked, want.matched_inputs,
                                     m_tdata[MATCH_W-1:0], want.match_map,
                                     m_tdata[MATCH_W +: MAPF_W]);
                    end
                end
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        logic [REQ_W-1:0] req;
        logic [REQ_W-1:0] used_bits;
        int               produced;
        int               burst;
        int               mode;

        used_bits = (PORTS * PORTS >= REQ_W) ? '1 : ((REQ_W'(1) << (PORTS * PORTS)) - 1);

        // Directed part. No requests must leave every pointer in place.
        queue_request('0);
        // Requests only in the ignored high bits; none exist at eight ports.
        queue_request(~used_bits);
        // Full matrix twice: pointers move and the second slot desynchronizes.
        queue_request('1);
        queue_request('1);
        // Lowest and highest single request bits.
        queue_request(REQ_W'(1));
        queue_request(REQ_W'(1) << (PORTS * PORTS - 1));
        // Complete permutations: the diagonal and the wrap-around shift.
        queue_request(shifted_permutation(0));
        queue_request(shifted_permutation(PORTS - 1));
        // A hotspot on the first and last output: the grant pointer rotates.
        for (int k = 0; k < 3; k++)
            queue_request(column_requests(0));
        queue_request(column_requests(PORTS - 1));
        // One input asking everywhere: the accept pointer rotates.
        for (int k = 0; k < 3; k++)
            queue_request(row_requests(0));
        queue_request(row_requests(PORTS - 1));
        // Alternating bit patterns, then a row plus a column, each with unmatched inputs left over.
        queue_request({(REQ_W/4){4'hA}});
        queue_request({(REQ_W/4){4'h5}});
        queue_request(column_requests(PORTS - 1) | row_requests(0));
        queue_request('0);

        // Random part. Dense traffic keeps the pointers moving through all
        // their states; bursts of one matrix show the round-robin rotation.
        produced = 0;
        while (produced < RANDOM_ITEMS) begin
            mode = $urandom_range(9);
            case (mode)
                0, 1, 2: begin
                    queue_request({$urandom, $urandom});
                    produced++;
                end
                3, 4: begin
                    // About one request in four.
                    queue_request({$urandom, $urandom} & {$urandom, $urandom});
                    produced++;
                end
                5: begin
                    req = '0;
                    for (int k = $urandom_range(1, 4); k > 0; k--)
                        req[$urandom_range(PORTS * PORTS - 1)] = 1'b1;
                    queue_request(req);
                    produced++;
                end
                6: begin
                    queue_request(
                        shifted_permutation($urandom_range(PORTS - 1)) |
                        ({$urandom, $urandom} & {$urandom, $urandom} &
                         {$urandom, $urandom}));
                    produced++;
                end
                7: begin
                    // The same matrix for several slots in a row.
                    req = $urandom_range(1) ? {REQ_W{1'b1}} :
                                              ({$urandom, $urandom} |
                                               {$urandom, $urandom});
                    burst = $urandom_range(4, 12);
                    for (int k = 0; k < burst; k++)
                        queue_request(req);
                    produced += burst;
                end
                8: begin
                    queue_request(
                        column_requests($urandom_range(PORTS - 1)) |
                        row_requests($urandom_range(PORTS - 1)) |
                        ({$urandom, $urandom} & {$urandom, $urandom}));
                    produced++;
                end
                default: begin
                    queue_request($urandom_range(1) ? {REQ_W{1'b1}} : {REQ_W{1'b0}});
                    produced++;
                end
            endcase
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every item is taken and every matching has come back.
        wait (pending_requests.size() == 0 && !s_tvalid);
        wait (expected_matches.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("tb: %0d slots scheduled on a %0dx%0d crossbar, %0d matchings checked",
                 slots_sent, PORTS, PORTS, results_checked);
        $display("tb: %0d slots fully matched, %0d slots with no match, %0d mismatches",
                 full_matchings, empty_slots, error_count);
        if (error_count == 0 && expected_matches.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
